>>> hw/rtl/rrab_pkg.sv
// ----------------------------------------------------------------------------
// rrab_pkg: shared types and constants
// Screen size, register indexes and the rectangle settings struct for the
// RGB565 rectangle alpha compositor.
// ----------------------------------------------------------------------------
package rrab_pkg;

	localparam int SCREEN_WIDTH  = 480;
	localparam int SCREEN_HEIGHT = 800;

	// 13 bits hold any screen size up to 2048 and any 12-bit signed coordinate
	localparam int CoordW = 13;

	localparam int ColW   = 9;
	localparam int RowW   = 10;
	localparam int PixW   = 16;
	localparam int AlphaW = 8;
	localparam int PosW   = 12;
	localparam int CfgAddrW = 3;
	localparam int CfgDataW = 16;

	localparam int InDataW  = 40;	// 35 payload bits padded to whole bytes
	localparam int OutDataW = 16;

	typedef enum logic [CfgAddrW-1:0] {
		REG_RECT_LEFT   = 3'd0,
		REG_RECT_TOP    = 3'd1,
		REG_RECT_WIDTH  = 3'd2,
		REG_RECT_HEIGHT = 3'd3,
		REG_FILL_COLOR  = 3'd4,
		REG_BLEND_ALPHA = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic signed [PosW-1:0] left;
		logic signed [PosW-1:0] top;
		logic        [PosW-1:0] width;
		logic        [PosW-1:0] height;
	} rect_cfg_t;

endpackage

>>> hw/rtl/rgb565_rect_alpha_blend_core.sv
// ----------------------------------------------------------------------------
// rgb565_rect_alpha_blend_core: rectangle fill compositor, RGB565
// Blends a constant-alpha fill color into pixels inside a rectangle and
// passes all other pixels through.
//
//   channel  dir  tdata (low bit up)                      tuser
//   s_axis   in   pixel_col, pixel_row, background_pixel  -
//   m_axis   out  pixel_value                             written
//   cfg      in   cfg_we / cfg_addr / cfg_wdata           -
//
// One pixel per clock while the sink takes each output word.
// Input register -> hit test and blend -> output register; the output
// register frees as soon as the sink takes its word, so input is stalled only
// while both stages hold words. Reset loads blend_alpha 255, other settings zero.
// ----------------------------------------------------------------------------
module rgb565_rect_alpha_blend_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rrab_pkg::CfgAddrW-1:0]     cfg_addr,
	input  logic [rrab_pkg::CfgDataW-1:0]     cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// pixel_col[8:0], pixel_row[18:9], background_pixel[34:19], zero pad
	input  logic [rrab_pkg::InDataW-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// pixel_value[15:0]
	output logic [rrab_pkg::OutDataW-1:0]     m_tdata,
	// written[0]
	output logic                              m_tuser
);
	import rrab_pkg::*;

	rect_cfg_t         rect_q;
	logic [PixW-1:0]   fill_q;
	logic [AlphaW-1:0] alpha_q;

	logic              vld_s1;
	logic [ColW-1:0]   col_s1;
	logic [RowW-1:0]   row_s1;
	logic [PixW-1:0]   bg_s1;

	logic              vld_s2;
	logic [PixW-1:0]   pix_s2;
	logic              written_s2;

	logic              adv_s2;
	logic              hit;
	logic              wr;
	logic [PixW-1:0]   mixed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_q  <= '0;
			fill_q  <= '0;
			alpha_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_RECT_LEFT:   rect_q.left   <= signed'(cfg_wdata[PosW-1:0]);
				REG_RECT_TOP:    rect_q.top    <= signed'(cfg_wdata[PosW-1:0]);
				REG_RECT_WIDTH:  rect_q.width  <= cfg_wdata[PosW-1:0];
				REG_RECT_HEIGHT: rect_q.height <= cfg_wdata[PosW-1:0];
				REG_FILL_COLOR:  fill_q        <= cfg_wdata;
				REG_BLEND_ALPHA: alpha_q       <= cfg_wdata[AlphaW-1:0];
				default: ;
			endcase
		end
	end

	assign adv_s2   = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			col_s1 <= s_tdata[8:0];
			row_s1 <= s_tdata[18:9];
			bg_s1  <= s_tdata[34:19];
		end
	end

	rrab_hit u_hit (
		.rect (rect_q),
		.col  (col_s1),
		.row  (row_s1),
		.hit  (hit)
	);

	rrab_mix u_mix (
		.fill  (fill_q),
		.bg    (bg_s1),
		.alpha (alpha_q),
		.mixed (mixed)
	);

	assign wr = hit && (alpha_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (!vld_s2 || m_tready) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			pix_s2     <= wr ? mixed : bg_s1;
			written_s2 <= wr;
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = pix_s2;
	assign m_tuser  = written_s2;

`ifndef SYNTHESIS
	a_empty_s1_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> s_tready)
		else $error("input stalled with empty input register");

	a_no_drop_s1: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !m_tready |=> vld_s1)
		else $error("word lost from input register while output stalled");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		(!vld_s2 || m_tready) && !vld_s1 |=> !vld_s2)
		else $error("output word without a source word");

	a_alpha_zero: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && alpha_q == '0 |=> !written_s2)
		else $error("pixel flagged written with zero alpha");
`endif

endmodule

>>> hw/rtl/rrab_hit.sv
// ----------------------------------------------------------------------------
// rrab_hit: rectangle hit test
// Flags a pixel that lies on screen and inside a non-empty rectangle.
// ----------------------------------------------------------------------------
module rrab_hit (
	input  rrab_pkg::rect_cfg_t          rect,
	input  logic [rrab_pkg::ColW-1:0]    col,
	input  logic [rrab_pkg::RowW-1:0]    row,
	output logic                         hit
);
	import rrab_pkg::*;

	logic signed [CoordW:0] col_x;
	logic signed [CoordW:0] row_x;
	logic signed [CoordW:0] left_x;
	logic signed [CoordW:0] top_x;
	logic signed [CoordW:0] right_x;
	logic signed [CoordW:0] bottom_x;
	logic                   on_screen;
	logic                   in_x;
	logic                   in_y;

	always_comb begin
		col_x    = (CoordW+1)'(signed'({1'b0, col}));
		row_x    = (CoordW+1)'(signed'({1'b0, row}));
		left_x   = (CoordW+1)'(rect.left);
		top_x    = (CoordW+1)'(rect.top);
		// exclusive right and bottom edges
		right_x  = left_x + (CoordW+1)'(signed'({1'b0, rect.width}));
		bottom_x = top_x + (CoordW+1)'(signed'({1'b0, rect.height}));
		on_screen = (CoordW'(col) < CoordW'(SCREEN_WIDTH)) &&
		            (CoordW'(row) < CoordW'(SCREEN_HEIGHT));
		in_x = (rect.width != '0) && (col_x >= left_x) && (col_x < right_x);
		in_y = (rect.height != '0) && (row_x >= top_x) && (row_x < bottom_x);
		hit  = on_screen && in_x && in_y;
	end

endmodule

>>> hw/rtl/rrab_mix.sv
// ----------------------------------------------------------------------------
// rrab_mix: RGB565 constant-alpha blend
// Per channel (fg*a + bg*(255-a))/255, rounded down.
// ----------------------------------------------------------------------------
module rrab_mix (
	input  logic [rrab_pkg::PixW-1:0]   fill,
	input  logic [rrab_pkg::PixW-1:0]   bg,
	input  logic [rrab_pkg::AlphaW-1:0] alpha,
	output logic [rrab_pkg::PixW-1:0]   mixed
);
	import rrab_pkg::*;

	// channel of up to 6 bits; x/255 = ((x+1)*257) >> 16 for x below 257*255
	function automatic logic [5:0] mix_ch(input logic [5:0] fg, input logic [5:0] bk,
		input logic [AlphaW-1:0] a);
		logic [AlphaW-1:0] a_inv;
		logic [13:0]       sum;
		logic [14:0]       sum_p1;
		logic [22:0]       scaled;
		a_inv  = 8'd255 - a;
		sum    = 14'(fg) * 14'(a) + 14'(bk) * 14'(a_inv);
		sum_p1 = 15'(sum) + 15'd1;
		scaled = {sum_p1, 8'd0} + 23'(sum_p1);
		return scaled[21:16];
	endfunction

	logic [5:0] r_mix;
	logic [5:0] g_mix;
	logic [5:0] b_mix;

	always_comb begin
		r_mix = mix_ch({1'b0, fill[15:11]}, {1'b0, bg[15:11]}, alpha);
		g_mix = mix_ch(fill[10:5], bg[10:5], alpha);
		b_mix = mix_ch({1'b0, fill[4:0]}, {1'b0, bg[4:0]}, alpha);
		mixed = {r_mix[4:0], g_mix, b_mix[4:0]};
	end

endmodule
